>>> src/gtp_pkg.sv
// ============================================================================
// gtp_pkg - shared types and constants for the grid tile packer
// Transaction payloads, register map and default sizing of the grid store.
// ============================================================================
`default_nettype none

package gtp_pkg;

    // default sizing of the grid store
    localparam int MAX_COLS_DEF  = 8;
    localparam int GRID_ROWS_DEF = 64;

    // search window and height limit
    localparam int SEARCH_ROWS = 64;
    localparam int HEIGHT_CAP  = 8;

    // register map, index of each register
    localparam logic REG_COLUMNS      = 1'b0;
    localparam logic REG_ROWS_VISIBLE = 1'b1;

    // register reset values
    localparam logic [3:0] COLUMNS_RST      = 4'd4;
    localparam logic [3:0] ROWS_VISIBLE_RST = 4'd3;

    // tile request transaction
    typedef struct packed {
        logic       new_wall;
        logic [3:0] span_width;
        logic [3:0] span_height;
    } req_t;

    // placement result transaction
    typedef struct packed {
        logic       placed;
        logic [5:0] tile_row;
        logic [2:0] tile_col;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/grid_tile_first_fit_packer.sv
// ============================================================================
// grid_tile_first_fit_packer - first-fit tile placement on an occupancy grid
// Places tiles in arrival order at the first row, then leftmost column, with
// room, starting from the row where the previous tile landed, or from row 0 after a new wall.
// ============================================================================
// One tile is worked on at a time. The search reads one occupancy row per
// memory access (a read state, then capture into a window of the last
// rows read); the first candidate row needs h reads before its check, every
// later candidate one more read. After a fit, the covered rows are written
// back one row per write. A new wall clears the grid at once through per-row
// valid bits. Results wait in an output register while the next tile is
// taken; the user must write configuration over the APB port only while the
// block is idle, and the block itself does not enforce this.
`default_nettype none

module grid_tile_first_fit_packer #(
    parameter int MAX_COLS  = gtp_pkg::MAX_COLS_DEF,
    parameter int GRID_ROWS = gtp_pkg::GRID_ROWS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    // tile requests
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire gtp_pkg::req_t req,
    // placement results
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output gtp_pkg::rsp_t      rsp
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int HCAP  = (GRID_ROWS < gtp_pkg::HEIGHT_CAP) ? GRID_ROWS : gtp_pkg::HEIGHT_CAP;
    localparam int KW    = $clog2(gtp_pkg::SEARCH_ROWS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [3:0]          columns_reg;
    logic [3:0]          rows_vis_reg;
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [RW-1:0]       scan_row_reg;
    logic [RW-1:0]       cand_reg;
    logic [RW-1:0]       rd_addr_reg;
    logic [RW-1:0]       wr_addr_reg;
    logic [3:0]          fill_reg;
    logic [3:0]          wcnt_reg;
    logic [KW-1:0]       kcnt_reg;
    logic [NCW-1:0]      ncols_reg;
    logic [NCW-1:0]      width_reg;
    logic [3:0]          height_reg;
    logic                placed_reg;
    logic [CLW-1:0]      col_reg;
    logic [MAX_COLS-1:0] win_reg [HCAP];
    logic                rsp_valid_reg;
    gtp_pkg::rsp_t       rsp_reg;

    logic [NCW-1:0]      ncols_c;
    logic [NCW-1:0]      width_c;
    logic [3:0]          hcap_c;
    logic [3:0]          height_c;
    logic [RW-1:0]       start_c;
    logic [MAX_COLS-1:0] base;
    logic [MAX_COLS-1:0] tile_mask;
    logic                fit_found;
    logic [CLW-1:0]      fit_col;
    logic [MAX_COLS-1:0] rd_data;
    logic                cfg_wr;
    logic                accept;
    logic                rsp_load;
    logic                start_over;
    logic                next_over;
    logic                clear_grid;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg  <= gtp_pkg::COLUMNS_RST;
            rows_vis_reg <= gtp_pkg::ROWS_VISIBLE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                gtp_pkg::REG_COLUMNS:      columns_reg  <= pwdata[3:0];
                gtp_pkg::REG_ROWS_VISIBLE: rows_vis_reg <= pwdata[3:0];
                default:                   columns_reg  <= columns_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            gtp_pkg::REG_COLUMNS:      prdata = {28'd0, columns_reg};
            gtp_pkg::REG_ROWS_VISIBLE: prdata = {28'd0, rows_vis_reg};
            default:                   prdata = '0;
        endcase
    end

    // span clamping
    always_comb
    begin
        if (columns_reg == 4'd0)
            ncols_c = NCW'(1);
        else if (32'(columns_reg) > 32'(MAX_COLS))
            ncols_c = NCW'(MAX_COLS);
        else
            ncols_c = NCW'(columns_reg);

        if (req.span_width == 4'd0)
            width_c = NCW'(1);
        else if (32'(req.span_width) > 32'(ncols_c))
            width_c = ncols_c;
        else
            width_c = NCW'(req.span_width);

        if (rows_vis_reg == 4'd0)
            hcap_c = 4'd1;
        else if (32'(rows_vis_reg) > 32'(HCAP))
            hcap_c = 4'(HCAP);
        else
            hcap_c = rows_vis_reg;

        if (req.span_height == 4'd0)
            height_c = 4'd1;
        else if (req.span_height > hcap_c)
            height_c = hcap_c;
        else
            height_c = req.span_height;
    end

    // run of cells covered by one row of the tile
    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            base[i] = (32'(i) < 32'(width_reg));
        end
    end

    assign tile_mask = base << col_reg;

    // search bounds against the end of the store
    assign start_c    = req.new_wall ? '0 : scan_row_reg;
    assign start_over = (32'(start_c) + 32'(height_c)) > 32'(GRID_ROWS);
    assign next_over  = (32'(cand_reg) + 32'd1 + 32'(height_reg)) > 32'(GRID_ROWS);

    assign accept     = req_valid && req_ready;
    assign clear_grid = accept && req.new_wall;
    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_load   = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // occupancy store
    gtp_occ_mem #(
        .ROWS (GRID_ROWS),
        .COLS (MAX_COLS)
    ) u_occ_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear_grid),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_WRITE),
        .wr_addr (wr_addr_reg),
        .wr_data (win_reg[0] | tile_mask)
    );

    // column search over the window
    gtp_fit #(
        .COLS  (MAX_COLS),
        .DEPTH (HCAP)
    ) u_fit (
        .win    (win_reg),
        .height (height_reg),
        .width  (width_reg),
        .ncols  (ncols_reg),
        .base   (base),
        .found  (fit_found),
        .col    (fit_col)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = start_over ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if ((fill_reg + 4'd1) >= height_reg)
                    state_next = ST_EVAL;
                else
                    state_next = ST_READ;
            end
            ST_EVAL:
            begin
                if (fit_found)
                    state_next = ST_WRITE;
                else if ((kcnt_reg == KW'(gtp_pkg::SEARCH_ROWS - 1)) || next_over)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_WRITE:
            begin
                if (wcnt_reg == 4'd1)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer and search registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_row_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_grid)
            begin
                scan_row_reg <= '0;
            end
            else if ((state_reg == ST_WRITE) && (wcnt_reg == 4'd1))
            begin
                scan_row_reg <= cand_reg;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ncols_reg   <= ncols_c;
                    width_reg   <= width_c;
                    height_reg  <= height_c;
                    cand_reg    <= start_c;
                    rd_addr_reg <= start_c;
                    fill_reg    <= 4'd0;
                    kcnt_reg    <= '0;
                    placed_reg  <= 1'b0;
                    col_reg     <= '0;
                end
            end
            ST_DATA:
            begin
                // shift the fresh row into the window
                win_reg[0] <= rd_data;
                for (int j = 1; j < HCAP; j++)
                begin
                    win_reg[j] <= win_reg[j-1];
                end
                rd_addr_reg <= rd_addr_reg + RW'(1);
                if (fill_reg < height_reg)
                    fill_reg <= fill_reg + 4'd1;
            end
            ST_EVAL:
            begin
                if (fit_found)
                begin
                    placed_reg  <= 1'b1;
                    col_reg     <= fit_col;
                    wcnt_reg    <= height_reg;
                    wr_addr_reg <= RW'(32'(cand_reg) + 32'(height_reg) - 32'd1);
                end
                else
                begin
                    cand_reg <= cand_reg + RW'(1);
                    kcnt_reg <= kcnt_reg + KW'(1);
                end
            end
            ST_WRITE:
            begin
                // write back from the bottom row up, newest window entry first
                for (int j = 0; j < HCAP - 1; j++)
                begin
                    win_reg[j] <= win_reg[j+1];
                end
                wr_addr_reg <= wr_addr_reg - RW'(1);
                wcnt_reg    <= wcnt_reg - 4'd1;
            end
            default:
            begin
                placed_reg <= placed_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.placed   <= placed_reg;
            rsp_reg.tile_row <= placed_reg ? 6'(cand_reg) : 6'd0;
            rsp_reg.tile_col <= placed_reg ? 3'(col_reg) : 3'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> src/gtp_occ_mem.sv
// ============================================================================
// gtp_occ_mem - occupancy store
// One row of cell bits per grid row, with a registered synchronous read.
// Per-row valid bits make a cleared or never written row read as free.
// ============================================================================
`default_nettype none

module gtp_occ_mem #(
    parameter int ROWS = gtp_pkg::GRID_ROWS_DEF,
    parameter int COLS = gtp_pkg::MAX_COLS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    clear,
    input  wire logic                    rd_en,
    input  wire logic [$clog2(ROWS)-1:0] rd_addr,
    output logic      [COLS-1:0]         rd_data,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_addr,
    input  wire logic [COLS-1:0]         wr_data
);

    logic [COLS-1:0] occ_mem [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [COLS-1:0] rdq_reg;
    logic            rdv_reg;

    // row storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdq_reg <= occ_mem[rd_addr];
        end
    end

    // row valid bits, cleared at once on reset or a new wall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rdv_reg <= valid_reg[rd_addr];
            end
        end
    end

    // a row never written since the last clear is all free
    assign rd_data = rdv_reg ? rdq_reg : '0;

endmodule

`default_nettype wire

>>> src/gtp_fit.sv
// ============================================================================
// gtp_fit - column fit search
// Merges the rows held in the window that a tile would cover and finds the
// leftmost column where the whole run of cells is free.
// ============================================================================
`default_nettype none

module gtp_fit #(
    parameter int COLS  = gtp_pkg::MAX_COLS_DEF,
    parameter int DEPTH = gtp_pkg::HEIGHT_CAP
) (
    input  wire logic [COLS-1:0]                         win [DEPTH],
    input  wire logic [3:0]                              height,
    input  wire logic [$clog2(COLS+1)-1:0]               width,
    input  wire logic [$clog2(COLS+1)-1:0]               ncols,
    input  wire logic [COLS-1:0]                         base,
    output logic                                         found,
    output logic      [((COLS > 1) ? $clog2(COLS) : 1)-1:0] col
);

    localparam int CLW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [COLS-1:0] occ_or;
    logic [COLS-1:0] fit;

    // merge the covered rows
    always_comb
    begin
        occ_or = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (32'(j) < 32'(height))
            begin
                occ_or = occ_or | win[j];
            end
        end
    end

    // each start column checked independently
    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            fit[c] = ((32'(c) + 32'(width)) <= 32'(ncols)) &&
                     ((occ_or & (base << c)) == '0);
        end
    end

    // leftmost fitting column
    always_comb
    begin
        col = '0;
        for (int c = COLS - 1; c >= 0; c--)
        begin
            if (fit[c])
            begin
                col = CLW'(c);
            end
        end
    end

    assign found = |fit;

endmodule

`default_nettype wire
